// ----- rtl/core/mrwt_pkg.sv -----
// Shared types and constants for the Miller-Rabin witness test core.
// No dependencies; imported by the controller, the datapath and the top level.
package mrwt_pkg;

  // Result codes carried by the verdict field.
  localparam logic [1:0] VERDICT_PRIME     = 2'd0;
  localparam logic [1:0] VERDICT_COMPOSITE = 2'd1;
  localparam logic [1:0] VERDICT_INVALID   = 2'd2;

  // Which modular product the shared multiplier forms, and where it lands.
  typedef enum logic [1:0] {
    MUL_REDUCE = 2'd0,  // 1 * witness mod n  -> base
    MUL_ACC    = 2'd1,  // acc * base mod n   -> acc
    MUL_SQB    = 2'd2,  // base * base mod n  -> base
    MUL_SQX    = 2'd3   // acc * acc mod n    -> acc
  } mul_op_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic    load;       // latch candidate and witness
    logic    init_exp;   // exponent = n-1, s = 0, acc = 1
    logic    strip;      // exponent >>= 1, s++
    logic    shift_exp;  // exponent >>= 1
    logic    sq_dec;     // s--
    logic    mul_start;  // launch a modular multiply
    mul_op_e mul_op;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic n_lt2;
    logic n_eq2;
    logic n_even;
    logic e_lsb;
    logic e_zero;
    logic mul_done;
    logic x_one;
    logic x_m1;
    logic s_gt1;
  } dp_sts_t;

endpackage

// ----- rtl/core/mrwt_mulmod.sv -----
// Bit-serial modular multiplier: r = a * b mod m, a < m, MSB of b first.
// Each multiplier bit takes a double step, then a conditional add step. No package use.
module mrwt_mulmod #(
  parameter int WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic [WIDTH-1:0] m_i,
  output logic             done_o,
  output logic [WIDTH-1:0] res_o
);

  localparam int CW = $clog2(WIDTH + 1);

  logic             run_q, done_q, phase_q;
  logic [CW-1:0]    cnt_q;
  logic [WIDTH-1:0] r_q, a_q, b_q, m_q;
  logic [WIDTH-1:0] addend, gap, r_d;

  // add_mod(r, addend, m) with both operands below m: never overflows WIDTH
  always_comb begin
    addend = phase_q ? (b_q[WIDTH-1] ? a_q : '0) : r_q;
    gap    = m_q - addend;
    r_d    = (r_q >= gap) ? (r_q - gap) : (r_q + addend);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else if (start_i) begin
      run_q   <= 1'b1;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= CW'(WIDTH);
    end else if (run_q) begin
      phase_q <= ~phase_q;
      if (phase_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q <= '0;
      a_q <= a_i;
      b_q <= b_i;
      m_q <= m_i;
    end else if (run_q) begin
      r_q <= r_d;
      if (phase_q) begin
        b_q <= {b_q[WIDTH-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = r_q;

endmodule

// ----- rtl/core/mrwt_dp.sv -----
// Datapath: candidate, witness, exponent, squaring count, acc and base registers
// around one shared mrwt_mulmod. Depends on mrwt_pkg and mrwt_mulmod.
module mrwt_dp #(
  parameter int WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [WIDTH-1:0]  candidate_i,
  input  logic [WIDTH-1:0]  witness_i,
  input  mrwt_pkg::dp_cmd_t cmd_i,
  output mrwt_pkg::dp_sts_t sts_o
);

  import mrwt_pkg::*;

  localparam int SW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] n_q, w_q, e_q, acc_q, b_q;
  logic [SW-1:0]    s_q;
  mul_op_e          op_q;

  logic [WIDTH-1:0] mul_a, mul_b, mul_res;
  logic             mul_done;

  // operand routing; a-side is always already reduced below n
  always_comb begin
    case (cmd_i.mul_op)
      MUL_REDUCE: begin
        mul_a = WIDTH'(1);
        mul_b = w_q;
      end
      MUL_ACC: begin
        mul_a = b_q;
        mul_b = acc_q;
      end
      MUL_SQB: begin
        mul_a = b_q;
        mul_b = b_q;
      end
      MUL_SQX: begin
        mul_a = acc_q;
        mul_b = acc_q;
      end
      default: begin
        mul_a = acc_q;
        mul_b = acc_q;
      end
    endcase
  end

  mrwt_mulmod #(.WIDTH(WIDTH)) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .m_i     (n_q),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q <= candidate_i;
      w_q <= witness_i;
    end
    if (cmd_i.init_exp) begin
      e_q   <= n_q - WIDTH'(1);
      s_q   <= '0;
      acc_q <= WIDTH'(1);
    end
    if (cmd_i.strip) begin
      e_q <= e_q >> 1;
      s_q <= s_q + SW'(1);
    end
    if (cmd_i.shift_exp) begin
      e_q <= e_q >> 1;
    end
    if (cmd_i.sq_dec) begin
      s_q <= s_q - SW'(1);
    end
    if (cmd_i.mul_start) begin
      op_q <= cmd_i.mul_op;
    end
    // writeback uses the op of the product that just finished
    if (mul_done) begin
      case (op_q)
        MUL_REDUCE, MUL_SQB: b_q   <= mul_res;
        MUL_ACC, MUL_SQX:    acc_q <= mul_res;
        default:             acc_q <= mul_res;
      endcase
    end
  end

  always_comb begin
    sts_o.n_lt2    = (n_q[WIDTH-1:1] == '0);
    sts_o.n_eq2    = (n_q == WIDTH'(2));
    sts_o.n_even   = ~n_q[0];
    sts_o.e_lsb    = e_q[0];
    sts_o.e_zero   = (e_q == '0);
    sts_o.mul_done = mul_done;
    sts_o.x_one    = (acc_q == WIDTH'(1));
    sts_o.x_m1     = (acc_q == (n_q - WIDTH'(1)));
    sts_o.s_gt1    = (s_q > SW'(1));
  end

endmodule

// ----- rtl/core/mrwt_ctrl.sv -----
// Sequencer for one witness round plus the output item register.
// Depends on mrwt_pkg; drives mrwt_dp through dp_cmd_t / dp_sts_t.
module mrwt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        verdict_o,
  output mrwt_pkg::dp_cmd_t cmd_o,
  input  mrwt_pkg::dp_sts_t sts_i
);

  import mrwt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASS,
    ST_STRIP,
    ST_REDUCE,
    ST_POW,
    ST_PMUL,
    ST_PSQR,
    ST_XTEST,
    ST_SQTEST,
    ST_SQWAIT,
    ST_SQCHK,
    ST_DONE
  } state_e;

  state_e     state_q;
  logic [1:0] res_q;
  logic       out_valid_q;
  logic [1:0] verdict_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.mul_op    = MUL_REDUCE;
    cmd_o.load      = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.init_exp  = (state_q == ST_CLASS);
    case (state_q)
      ST_STRIP: begin
        if (sts_i.e_lsb) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_op    = MUL_REDUCE;
        end else begin
          cmd_o.strip = 1'b1;
        end
      end
      ST_POW: begin
        if (!sts_i.e_zero) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_op    = sts_i.e_lsb ? MUL_ACC : MUL_SQB;
        end
      end
      ST_PMUL: begin
        if (sts_i.mul_done) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_op    = MUL_SQB;
        end
      end
      ST_PSQR: begin
        cmd_o.shift_exp = sts_i.mul_done;
      end
      ST_SQTEST: begin
        if (sts_i.s_gt1) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_op    = MUL_SQX;
          cmd_o.sq_dec    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_q       <= VERDICT_INVALID;
      out_valid_q <= 1'b0;
      verdict_q   <= VERDICT_INVALID;
    end else begin
      // output register: load a finished verdict, else drain on accept
      if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
        verdict_q   <= res_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_CLASS;
        end
        ST_CLASS: begin
          if (sts_i.n_lt2) begin
            res_q   <= VERDICT_INVALID;
            state_q <= ST_DONE;
          end else if (sts_i.n_eq2) begin
            res_q   <= VERDICT_PRIME;
            state_q <= ST_DONE;
          end else if (sts_i.n_even) begin
            res_q   <= VERDICT_COMPOSITE;
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_STRIP;
          end
        end
        ST_STRIP: begin
          if (sts_i.e_lsb) state_q <= ST_REDUCE;
        end
        ST_REDUCE: begin
          if (sts_i.mul_done) state_q <= ST_POW;
        end
        ST_POW: begin
          if (sts_i.e_zero) begin
            state_q <= ST_XTEST;
          end else if (sts_i.e_lsb) begin
            state_q <= ST_PMUL;
          end else begin
            state_q <= ST_PSQR;
          end
        end
        ST_PMUL: begin
          if (sts_i.mul_done) state_q <= ST_PSQR;
        end
        ST_PSQR: begin
          if (sts_i.mul_done) state_q <= ST_POW;
        end
        ST_XTEST: begin
          if (sts_i.x_one || sts_i.x_m1) begin
            res_q   <= VERDICT_PRIME;
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_SQTEST;
          end
        end
        ST_SQTEST: begin
          if (sts_i.s_gt1) begin
            state_q <= ST_SQWAIT;
          end else begin
            res_q   <= VERDICT_COMPOSITE;
            state_q <= ST_DONE;
          end
        end
        ST_SQWAIT: begin
          if (sts_i.mul_done) state_q <= ST_SQCHK;
        end
        ST_SQCHK: begin
          if (sts_i.x_m1) begin
            res_q   <= VERDICT_PRIME;
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_SQTEST;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

endmodule

// ----- rtl/core/miller_rabin_witness_test_core.sv -----
// Verdict path: a candidate below three or even is classified without any product;
//   otherwise the witness is reduced, raised to d and squared up to s-1 times, each
//   product formed on the shared multiplier.
// Throughput: one item at a time; the single bit-serial multiplier sets the pace.
//   The next item is taken while the previous verdict waits in the output register.
// Reset: asynchronous, active low; clears the sequencer, the output register and the multiplier control.
module miller_rabin_witness_test_core #(
  parameter int WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input item channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [WIDTH-1:0] candidate_i,
  input  logic [WIDTH-1:0] witness_i,
  // result item channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       verdict_o
);

  import mrwt_pkg::*;

  // Command / status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: classifies the candidate, strips factors of two from n-1,
  // walks the exponent right to left, then runs the squaring chain.
  mrwt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .verdict_o   (verdict_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Datapath: operand registers and the shared modular multiplier.
  // The witness is reduced mod n as the product 1 * witness.
  mrwt_dp #(.WIDTH(WIDTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .candidate_i (candidate_i),
    .witness_i   (witness_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ----- rtl/core/mrwt_checker.sv -----
// Port-level checks for miller_rabin_witness_test_core, attached by bind.
// No package use; sees only the top-level handshake ports.
module mrwt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] verdict_o
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(verdict_o))
    else $error("verdict dropped or changed while stalled");

  // an accepted item makes the engine busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice in a row");

  // a new verdict only comes out of a busy engine
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("verdict appeared with no item in work");

  // no verdict on the edge right after accept
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("verdict too early");

endmodule

bind miller_rabin_witness_test_core mrwt_checker u_mrwt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .verdict_o   (verdict_o)
);
